/* rtl/mrtu_pkg.sv */
// shared constants, types and crc function for the modbus rtu slave framer
package mrtu_pkg;

  // frame size limit and the byte counter width it needs
  localparam int MAX_FRAME_BYTES = 256;
  localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

  // input commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // configuration register indexes
  localparam int           CFG_IDX_W         = 2;
  localparam logic [1:0]   REG_STATION_ADDR  = 2'd0;
  localparam logic [1:0]   REG_TIMEOUT_MS    = 2'd1;

  // reset values of the configuration registers
  localparam logic [7:0]   STATION_ADDR_RST  = 8'd1;
  localparam logic [7:0]   TIMEOUT_MS_RST    = 8'd10;

  // crc-16 parameters
  localparam logic [15:0]  CRC_INIT = 16'hFFFF;
  localparam logic [15:0]  CRC_POLY = 16'hA001;

  // function codes and frame layout
  localparam logic [7:0]   FUNC_READ_FIRST    = 8'h01;
  localparam logic [7:0]   FUNC_READ_DISCRETE = 8'h02;
  localparam logic [7:0]   FUNC_READ_HOLDING  = 8'h03;
  localparam logic [7:0]   FUNC_READ_LAST     = 8'h04;
  localparam logic [7:0]   FUNC_WRITE_COIL    = 8'h05;
  localparam logic [7:0]   FUNC_WRITE_REG     = 8'h06;
  localparam logic [7:0]   FUNC_WRITE_COILS   = 8'h0F;
  localparam logic [7:0]   FUNC_WRITE_REGS    = 8'h10;
  localparam logic [7:0]   EXC_FLAG          = 8'h80;
  localparam logic [7:0]   EXC_ILLEGAL_FUNC  = 8'h01;
  localparam logic [7:0]   EXC_ILLEGAL_ADDR  = 8'h02;
  localparam int           POS_ADDRESS       = 0;
  localparam int           POS_FUNCTION      = 1;
  localparam int           POS_LENGTH        = 6;
  localparam int           CHECK_FROM_COUNT  = 5;
  localparam int           FIXED_FRAME_BYTES = 8;
  localparam int           LEN_MIN_COUNT     = 7;
  localparam int           LEN_OVERHEAD      = 9;

  // response layout: address, function, code, crc low, crc high
  localparam int           RESP_BYTES = 5;
  localparam int           RESP_IDX_W = 3;
  localparam logic [2:0]   RESP_ADDR    = 3'd0;
  localparam logic [2:0]   RESP_FUNC    = 3'd1;
  localparam logic [2:0]   RESP_CODE    = 3'd2;
  localparam logic [2:0]   RESP_CRC_LO  = 3'd3;
  localparam logic [2:0]   RESP_CRC_HI  = 3'd4;

  // queue between parser and responder
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one pending exception response
  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] func;
    logic [7:0] code;
  } resp_t;

  // one byte of reflected crc-16
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/mrtu_front.sv */
// frame parser: counts bytes, runs the crc, checks address and function
module mrtu_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_command,
  input  logic [7:0]          in_rx_byte,
  input  logic [7:0]          station_addr,
  input  logic [7:0]          timeout_ms,
  input  logic                q_full,
  output logic                q_push,
  output mrtu_pkg::resp_t     q_data
);
  import mrtu_pkg::*;

  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]       func_r, func_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       first_r, first_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       idle_r, idle_nxt;
  logic             accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // next frame state and response decision
  always_comb begin
    logic [CNT_W-1:0] cnt;
    logic [15:0]      crc_new;
    logic [7:0]       first_v, func_v, len_v;
    logic             complete, clear, send;
    logic [7:0]       code;

    byte_count_nxt = byte_count_r;
    func_nxt       = func_r;
    len_nxt        = len_r;
    first_nxt      = first_r;
    crc_nxt        = crc_r;
    idle_nxt       = idle_r;
    q_push         = 1'b0;
    q_data         = '0;

    cnt      = byte_count_r + CNT_W'(1);
    crc_new  = crc_byte(crc_r, in_rx_byte);
    first_v  = (byte_count_r == CNT_W'(POS_ADDRESS))  ? in_rx_byte : first_r;
    func_v   = (byte_count_r == CNT_W'(POS_FUNCTION)) ? in_rx_byte : func_r;
    len_v    = (byte_count_r == CNT_W'(POS_LENGTH))   ? in_rx_byte : len_r;
    complete = 1'b0;
    clear    = 1'b0;
    send     = 1'b0;
    code     = EXC_ILLEGAL_FUNC;

    if (accept) begin
      if (in_command == CMD_TICK) begin
        // idle timer, saturating
        if (idle_r != 8'hFF) begin
          idle_nxt = idle_r + 8'd1;
        end
        if (idle_nxt > timeout_ms) begin
          clear = 1'b1;
        end
      end else begin
        idle_nxt = 8'd0;
        if (cnt >= CNT_W'(CHECK_FROM_COUNT)) begin
          priority if (first_v != station_addr) begin
            clear = 1'b1;
          end else if (func_v >= FUNC_READ_FIRST && func_v <= FUNC_WRITE_REG) begin
            complete = (cnt == CNT_W'(FIXED_FRAME_BYTES));
          end else if (func_v == FUNC_WRITE_COILS || func_v == FUNC_WRITE_REGS) begin
            complete = (cnt >= CNT_W'(LEN_MIN_COUNT)) &&
                       (16'(cnt) == 16'(len_v) + 16'(LEN_OVERHEAD));
          end else begin
            // unknown function answers at once
            clear = 1'b1;
            send  = 1'b1;
          end
        end
        if (complete) begin
          clear = 1'b1;
          send  = (crc_new == 16'h0000);
          code  = (func_v <= FUNC_READ_LAST) ? EXC_ILLEGAL_ADDR : EXC_ILLEGAL_FUNC;
        end
        if (!clear) begin
          if (cnt >= CNT_W'(MAX_FRAME_BYTES)) begin
            clear = 1'b1;
          end else begin
            byte_count_nxt = cnt;
            first_nxt      = first_v;
            func_nxt       = func_v;
            len_nxt        = len_v;
            crc_nxt        = crc_new;
          end
        end
      end

      if (clear) begin
        byte_count_nxt = '0;
        func_nxt       = 8'h00;
        len_nxt        = 8'h00;
        first_nxt      = 8'h00;
        crc_nxt        = CRC_INIT;
      end
      if (send) begin
        q_push      = 1'b1;
        q_data.addr = station_addr;
        q_data.func = func_v | EXC_FLAG;
        q_data.code = code;
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      func_r       <= 8'h00;
      len_r        <= 8'h00;
      first_r      <= 8'h00;
      crc_r        <= CRC_INIT;
      idle_r       <= 8'h00;
    end else begin
      byte_count_r <= byte_count_nxt;
      func_r       <= func_nxt;
      len_r        <= len_nxt;
      first_r      <= first_nxt;
      crc_r        <= crc_nxt;
      idle_r       <= idle_nxt;
    end
  end

endmodule

/* rtl/mrtu_queue.sv */
// short fifo of pending responses between parser and responder
module mrtu_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mrtu_pkg::resp_t  push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output mrtu_pkg::resp_t  pop_data
);
  import mrtu_pkg::*;

  resp_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("response queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("response queue read while empty");
  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + QCNT_W'(1)))
    else $error("response queue count did not follow a lone push");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("response queue count beyond depth");
`endif

endmodule

/* rtl/mrtu_back.sv */
// responder: sends each queued exception as five bytes with trailing crc
module mrtu_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  mrtu_pkg::resp_t  q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_tx_byte,
  output logic             out_last
);
  import mrtu_pkg::*;

  logic                  busy_r, busy_nxt;
  logic [RESP_IDX_W-1:0] idx_r, idx_nxt;
  resp_t                 resp_r, resp_nxt;
  logic [15:0]           crc_r, crc_nxt;
  logic                  xfer;
  logic                  done;

  assign out_valid = busy_r;
  assign out_last  = busy_r && (idx_r == RESP_CRC_HI);
  assign xfer      = busy_r && !out_stall;
  assign done      = xfer && (idx_r == RESP_CRC_HI);
  assign q_pop     = !q_empty && (!busy_r || done);

  // byte select for the current position
  always_comb begin
    unique case (idx_r)
      RESP_ADDR:   out_tx_byte = resp_r.addr;
      RESP_FUNC:   out_tx_byte = resp_r.func;
      RESP_CODE:   out_tx_byte = resp_r.code;
      RESP_CRC_LO: out_tx_byte = crc_r[7:0];
      RESP_CRC_HI: out_tx_byte = crc_r[15:8];
      default:     out_tx_byte = 8'h00;
    endcase
  end

  // sequencing across the response bytes
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    resp_nxt = resp_r;
    crc_nxt  = crc_r;
    if (xfer) begin
      idx_nxt = idx_r + RESP_IDX_W'(1);
      if (idx_r < RESP_CRC_LO) begin
        crc_nxt = crc_byte(crc_r, out_tx_byte);
      end
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = RESP_ADDR;
      resp_nxt = q_data;
      crc_nxt  = CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= RESP_ADDR;
      crc_r  <= CRC_INIT;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      crc_r  <= crc_nxt;
    end
  end

  // response payload holds no control state
  always_ff @(posedge clk) begin
    resp_r <= resp_nxt;
  end

endmodule

/* rtl/modbus_rtu_slave_framer.sv */
// top level of the modbus rtu slave receive framer with exception responder
//
// Input channel (in_valid / in_stall): each transfer is either a received
// byte (in_command = 0, in_rx_byte) or a one millisecond tick (in_command = 1).
// Output channel (out_valid / out_stall): exception responses, five bytes each
// (address, function | 0x80, code, crc low, crc high); out_last marks crc high.
// Config channel (cfg_valid / cfg_ready): index 0 sets the station address,
// index 1 the idle timeout in ticks; cfg_ready is always high.
// Throughput: one input transfer per cycle while in_stall is low; the crc
// runs one byte per cycle. A response leaves at one byte per cycle while
// out_stall is low. The first response byte is offered once the response
// to the transfer that finishes the frame is registered in the queue and then
// in the responder. A two-entry response queue sits between parser and
// responder; in_stall rises only while that queue is full. While out_stall
// is high the current byte holds and the parser keeps taking input until
// the queue fills. Reset clears the frame, the idle timer and the queue, and
// loads the station address with 1 and the timeout with 10.
module modbus_rtu_slave_framer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_command,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_tx_byte,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mrtu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import mrtu_pkg::*;

  logic [7:0] station_addr_r;
  logic [7:0] timeout_ms_r;
  logic       q_full;
  logic       q_empty;
  logic       q_push;
  logic       q_pop;
  resp_t      q_wdata;
  resp_t      q_rdata;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_addr_r <= STATION_ADDR_RST;
      timeout_ms_r   <= TIMEOUT_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_STATION_ADDR) begin
        station_addr_r <= cfg_data;
      end else if (cfg_index == REG_TIMEOUT_MS) begin
        timeout_ms_r <= cfg_data;
      end
    end
  end

  // frame parser
  mrtu_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_rx_byte    (in_rx_byte),
    .station_addr  (station_addr_r),
    .timeout_ms    (timeout_ms_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  // pending responses
  mrtu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_rdata)
  );

  // response sender
  mrtu_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_tx_byte (out_tx_byte),
    .out_last    (out_last)
  );

endmodule

/* test/modbus_rtu_slave_framer_checker.sv */
`timescale 1ns / 1ps
// response predictor and scoreboard for the modbus rtu slave framer
module modbus_rtu_slave_framer_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_command,
  input  logic [7:0]                     in_rx_byte,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [7:0]                     out_tx_byte,
  input  logic                           out_last,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [mrtu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  output int                             mismatch_count,
  output int                             responses_owed
);
  import mrtu_pkg::*;

  // one byte of an exception response as it should leave the block
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } reply_byte_t;

  reply_byte_t reply_q[$];

  // register copies and frame state of the predictor
  logic [7:0]  station_addr;
  logic [7:0]  idle_limit;
  logic [7:0]  idle_ticks;
  logic [7:0]  req_addr;
  logic [7:0]  req_func;
  logic [7:0]  req_len_field;
  logic [15:0] req_crc;
  int          req_count;

  // reflected crc-16, one byte
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void drop_frame();
    req_count     = 0;
    req_addr      = 8'h00;
    req_func      = 8'h00;
    req_len_field = 8'h00;
    req_crc       = CRC_INIT;
  endfunction

  // five response bytes: station, function with flag, code, crc low, crc high
  function automatic void queue_reply(input logic [7:0] func, input logic [7:0] code);
    logic [7:0]  resp [RESP_BYTES];
    logic [15:0] c;
    resp[RESP_ADDR] = station_addr;
    resp[RESP_FUNC] = func | EXC_FLAG;
    resp[RESP_CODE] = code;
    c = CRC_INIT;
    for (int k = 0; k < int'(RESP_CRC_LO); k++) begin
      c = crc16_step(c, resp[k]);
    end
    resp[RESP_CRC_LO] = c[7:0];
    resp[RESP_CRC_HI] = c[15:8];
    for (int k = 0; k < RESP_BYTES; k++) begin
      reply_q.push_back('{resp[k], (k == RESP_BYTES - 1)});
    end
  endfunction

  // advance the frame state by one accepted input transfer
  function automatic void predict_transfer(input logic cmd, input logic [7:0] data);
    int         count;
    bit         done;
    bit         crc_ok;
    logic [7:0] func;
    if (cmd == CMD_TICK) begin
      if (idle_ticks != 8'hFF) idle_ticks++;
      if (idle_ticks > idle_limit) drop_frame();
      return;
    end
    idle_ticks = 8'h00;
    case (req_count)
      POS_ADDRESS:  req_addr = data;
      POS_FUNCTION: req_func = data;
      POS_LENGTH:   req_len_field = data;
      default: ;
    endcase
    req_crc = crc16_step(req_crc, data);
    count   = req_count + 1;
    func    = req_func;
    done    = 1'b0;
    if (count >= CHECK_FROM_COUNT) begin
      // foreign station: dropped without a word
      if (req_addr != station_addr) begin
        drop_frame();
        return;
      end
      if (func >= FUNC_READ_FIRST && func <= FUNC_WRITE_REG) begin
        done = (count == FIXED_FRAME_BYTES);
      end else if (func == FUNC_WRITE_COILS || func == FUNC_WRITE_REGS) begin
        done = (count >= LEN_MIN_COUNT) && (count == int'(req_len_field) + LEN_OVERHEAD);
      end else begin
        // unsupported function answers right away
        drop_frame();
        queue_reply(func, EXC_ILLEGAL_FUNC);
        return;
      end
    end
    if (done) begin
      crc_ok = (req_crc == 16'h0000);
      drop_frame();
      if (crc_ok) begin
        queue_reply(func, (func <= FUNC_READ_LAST) ? EXC_ILLEGAL_ADDR : EXC_ILLEGAL_FUNC);
      end
      return;
    end
    // too long without completing: whole frame thrown away
    if (count >= MAX_FRAME_BYTES) begin
      drop_frame();
      return;
    end
    req_count = count;
  endfunction

  // compare one response transfer with the oldest expected byte
  function automatic void check_reply();
    reply_byte_t want;
    if (reply_q.size() == 0) begin
      if (mismatch_count < 10) begin
        $display("unexpected response byte: tx_byte %02h last %0b", out_tx_byte, out_last);
      end
      mismatch_count++;
      return;
    end
    want = reply_q.pop_front();
    if (out_tx_byte !== want.tx_byte || out_last !== want.last) begin
      if (mismatch_count < 10) begin
        $display("response mismatch: expected tx_byte %02h last %0b, got tx_byte %02h last %0b",
                 want.tx_byte, want.last, out_tx_byte, out_last);
      end
      mismatch_count++;
    end
  endfunction

  // watch all three channels at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      station_addr   = STATION_ADDR_RST;
      idle_limit     = TIMEOUT_MS_RST;
      idle_ticks     = 8'h00;
      mismatch_count = 0;
      drop_frame();
      reply_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STATION_ADDR: station_addr = cfg_data;
          REG_TIMEOUT_MS:   idle_limit = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_reply();
      if (in_valid && !in_stall) predict_transfer(in_command, in_rx_byte);
    end
    responses_owed = reply_q.size();
  end

endmodule

/* test/modbus_rtu_slave_framer_test.sv */
`timescale 1ns / 1ps
// stimulus, clock, reset and verdict for the modbus rtu slave framer
module modbus_rtu_slave_framer_test;
  import mrtu_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_ITEMS  = 210;
  localparam int RANDOM_PHASES = 6;
  localparam int SETTLE_CYCLES = 6;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_command;
  logic [7:0]           in_rx_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [7:0]           out_tx_byte;
  logic                 out_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  int         mismatch_count;
  int         responses_owed;
  int         idle_cycles = 0;
  int         items_sent;
  bit         steady_input;
  logic [7:0] own_addr;
  logic [7:0] idle_limit;
  logic [7:0] frame_q[$];

  modbus_rtu_slave_framer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_tx_byte(out_tx_byte),
    .out_last   (out_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  modbus_rtu_slave_framer_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tx_byte   (out_tx_byte),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatch_count),
    .responses_owed(responses_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_func();
    int r;
    r = $urandom_range(0, 7);
    if (r < 6) return 8'(r + 1);
    return (r == 6) ? FUNC_WRITE_COILS : FUNC_WRITE_REGS;
  endfunction

  function automatic int pick_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
  endfunction

  // crc over everything in frame_q so far
  function automatic logic [15:0] crc_of_frame();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (frame_q[i]) begin
      c ^= {8'h00, frame_q[i]};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // full request; length byte and payload for the multi-write codes
  task automatic build_frame(input logic [7:0] addr, input logic [7:0] func,
                             input int data_n, input bit bad_crc);
    logic [15:0] c;
    frame_q.delete();
    frame_q.push_back(addr);
    frame_q.push_back(func);
    repeat (4) frame_q.push_back(8'($urandom));
    if (func == FUNC_WRITE_COILS || func == FUNC_WRITE_REGS) begin
      frame_q.push_back(8'(data_n));
      repeat (data_n) frame_q.push_back(8'($urandom));
    end
    c = crc_of_frame();
    if (bad_crc) c ^= 16'(1 << $urandom_range(0, 15));
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
  endtask

  // five bytes: enough for the address and function checks
  task automatic build_stub(input logic [7:0] addr, input logic [7:0] func);
    frame_q.delete();
    frame_q.push_back(addr);
    frame_q.push_back(func);
    repeat (3) frame_q.push_back(8'($urandom));
  endtask

  // one input transfer; entered and left at a falling edge
  task automatic send_item(input logic cmd, input logic [7:0] data);
    int gap;
    gap = steady_input ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_rx_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(CMD_TICK, 8'($urandom));
  endtask

  // bytes first..upto-1 of frame_q, with idle ticks that stay within the timeout
  task automatic send_frame(input int first, input int upto);
    for (int i = first; i < upto; i++) begin
      if (idle_limit != 8'd0 && $urandom_range(0, 19) == 0) begin
        send_ticks($urandom_range(1, (idle_limit < 8) ? int'(idle_limit) : 8));
      end
      send_item(CMD_BYTE, frame_q[i]);
    end
  endtask

  // hold input until every response is out, then let the block settle
  task automatic drain_results(input int settle);
    in_valid <= 1'b0;
    while (responses_owed != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] addr, input logic [7:0] limit);
    drain_results(SETTLE_CYCLES);
    write_reg(REG_STATION_ADDR, addr);
    write_reg(REG_TIMEOUT_MS, limit);
    cfg_valid  <= 1'b0;
    own_addr   = addr;
    idle_limit = limit;
  endtask

  // mostly well-formed requests, the rest broken or noise
  task automatic random_frame();
    int         kind;
    logic [7:0] func;
    kind = $urandom_range(0, 99);
    func = pick_func();
    if (kind < 62 || (kind >= 84 && idle_limit >= 40)) begin
      build_frame(own_addr, func, pick_len(), 1'b0);
      send_frame(0, frame_q.size());
    end else if (kind < 70) begin
      build_frame(own_addr, func, pick_len(), 1'b1);
      send_frame(0, frame_q.size());
    end else if (kind < 78) begin
      do func = 8'($urandom);
      while ((func >= FUNC_READ_FIRST && func <= FUNC_WRITE_REG) ||
             func == FUNC_WRITE_COILS || func == FUNC_WRITE_REGS);
      build_stub(own_addr, func);
      send_frame(0, frame_q.size());
    end else if (kind < 84) begin
      build_stub(own_addr ^ 8'($urandom_range(1, 255)), func);
      send_frame(0, frame_q.size());
    end else begin
      // cut short or pure noise, then cleared by the idle timeout
      if (kind < 92) begin
        build_frame(own_addr, func, pick_len(), 1'b0);
        send_frame(0, $urandom_range(1, frame_q.size() - 1));
      end else begin
        frame_q.delete();
        repeat ($urandom_range(1, 7)) frame_q.push_back(8'($urandom));
        send_frame(0, frame_q.size());
      end
      send_ticks(int'(idle_limit) + 1);
    end
  endtask

  // response side stalls in bursts, with long free-running stretches
  initial begin : out_stall_gen
    int run;
    int hold;
    out_stall <= 1'b0;
    @(negedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
      repeat (run) @(negedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // no transfer on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int phase_end;
    in_valid     <= 1'b0;
    in_command   <= CMD_BYTE;
    in_rx_byte   <= 8'h00;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_STATION_ADDR;
    cfg_data     <= 8'h00;
    rst_n        <= 1'b0;
    own_addr     = STATION_ADDR_RST;
    idle_limit   = TIMEOUT_MS_RST;
    steady_input = 1'b0;
    items_sent   = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: read answer, unknown function, bad crc, foreign station
    build_frame(own_addr, FUNC_READ_LAST, 0, 1'b0);
    send_frame(0, frame_q.size());
    build_stub(own_addr, 8'hFF);
    send_frame(0, frame_q.size());
    build_frame(own_addr, FUNC_WRITE_REGS, 0, 1'b1);
    send_frame(0, frame_q.size());
    build_stub(own_addr ^ 8'h80, FUNC_READ_HOLDING);
    send_frame(0, frame_q.size());

    // idle right at the timeout keeps the frame, one tick more clears it
    build_frame(own_addr, FUNC_WRITE_REG, 0, 1'b0);
    send_frame(0, 6);
    send_ticks(int'(idle_limit));
    send_frame(6, frame_q.size());
    build_frame(own_addr, FUNC_READ_HOLDING, 0, 1'b0);
    send_frame(0, 6);
    send_ticks(int'(idle_limit) + 1);
    build_frame(own_addr, FUNC_READ_FIRST, 0, 1'b0);
    send_frame(0, frame_q.size());

    // top address, zero timeout: any tick drops a partial frame
    set_config(8'hFF, 8'd0);
    build_frame(own_addr, FUNC_READ_FIRST, 0, 1'b0);
    send_frame(0, 4);
    send_ticks(1);
    build_frame(own_addr, FUNC_WRITE_COILS, 1, 1'b0);
    send_frame(0, frame_q.size());
    build_stub(own_addr, 8'h00);
    send_frame(0, frame_q.size());

    // address zero, timeout that never expires even with the counter saturated
    set_config(8'h00, 8'hFF);
    build_frame(own_addr, FUNC_WRITE_COIL, 0, 1'b0);
    send_frame(0, 3);
    send_ticks(300);
    send_frame(3, frame_q.size());
    build_frame(own_addr, FUNC_READ_DISCRETE, 0, 1'b0);
    send_frame(0, frame_q.size());

    // overflow: longest write cut off at the frame limit, then a normal request
    steady_input = 1'b1;
    build_frame(own_addr, FUNC_WRITE_REGS, 255, 1'b0);
    send_frame(0, MAX_FRAME_BYTES);
    steady_input = 1'b0;
    build_frame(own_addr, FUNC_READ_FIRST, 0, 1'b0);
    send_frame(0, frame_q.size());

    // random phases over several settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       set_config(8'hFF, 8'($urandom_range(1, 20)));
        1:       set_config(8'h00, 8'($urandom_range(1, 20)));
        2:       set_config(8'($urandom), 8'd0);
        3:       set_config(8'($urandom), 8'hFF);
        default: set_config(8'($urandom), 8'($urandom_range(1, 20)));
      endcase
      steady_input = (p == 4);
      phase_end = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (items_sent < phase_end) begin
        random_frame();
        if (p == 2 && items_sent < phase_end - 20) drain_results(0);
      end
    end

    drain_results(SETTLE_CYCLES);
    if (mismatch_count == 0 && responses_owed == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
